// ----- src/adlf_pkg.sv -----
// Package for the adjacent duplicate line filter.
// Holds the beat payload types, the configuration register indexes and shared constants.
// Has no dependencies of its own.
package adlf_pkg;

	// Default key store depth, in bytes; the longest line, newline included, is one byte less.
	localparam int unsigned LINE_MAX_DEF = 1024;

	// Configuration port geometry.
	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 11;

	// Configuration register indexes.
	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_UNIQUE_ONLY   = 3'd0,
		CFG_REPEATED_ONLY = 3'd1,
		CFG_SHOW_COUNT    = 3'd2,
		CFG_SKIP_FIELDS   = 3'd3,
		CFG_SKIP_CHARS    = 3'd4
	} cfg_index_t;

	// Byte that ends a line.
	localparam logic [7:0] NEWLINE = 8'd10;

	// One input beat: a text byte or the end of text marker.
	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} in_item_t;

	// One result beat: a closed group.
	typedef struct packed {
		logic [31:0] first_line;
		logic [31:0] occurrences;
	} out_item_t;

endpackage

// ----- src/adjacent_duplicate_line_filter.sv -----
// A group report sits in the output register from the cycle after the beat that closes it.
// Throughput: one input beat per cycle; the input stalls only while a report waits to be taken.
// Each byte does one key store write and one compare against a key byte prefetched the cycle
// before from the group's store, so nothing limits the rate but the output handshake.
// Reset clears all control state at once; the two key stores are not cleared and need no pass.
module adjacent_duplicate_line_filter
	import adlf_pkg::*;
#(
	parameter int unsigned LINE_MAX = LINE_MAX_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// Text input channel.
	input  logic                   in_valid,
	output logic                   in_ready,
	input  in_item_t               in_data,
	// Group report channel.
	output logic                   out_valid,
	input  logic                   out_ready,
	output out_item_t              out_data,
	// Configuration write port.
	input  logic                   cfg_write,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int unsigned AW = $clog2(LINE_MAX);
	localparam logic [AW-1:0] LAST_POS = AW'(LINE_MAX - 1);

	typedef enum logic [1:0] {
		PH_LEAD,
		PH_FIELD,
		PH_GAP,
		PH_CHARS
	} phase_t;

	// Configuration registers.
	logic        unique_only_q;
	logic        repeated_only_q;
	logic        show_count_q;
	logic [7:0]  skip_fields_q;
	logic [10:0] skip_chars_q;

	// Line and group state.
	logic          active_q;
	logic [AW-1:0] group_len_q;
	logic [AW-1:0] line_len_q;
	logic [AW-1:0] pos_q;
	phase_t        phase_q;
	logic [7:0]    fields_left_q;
	logic [10:0]   chars_left_q;
	logic          differs_q;
	logic          group_open_q;
	logic [31:0]   group_count_q;
	logic [31:0]   group_start_q;
	logic [31:0]   line_number_q;

	// Output register.
	logic      out_valid_q;
	out_item_t out_q;

	// Key stores and their prefetched read data.
	logic [7:0] store_a [LINE_MAX];
	logic [7:0] store_b [LINE_MAX];
	logic [7:0] rdata_a_q;
	logic [7:0] rdata_b_q;

	// Next state.
	logic          nxt_active;
	logic [AW-1:0] nxt_group_len;
	logic [AW-1:0] nxt_line_len;
	logic [AW-1:0] nxt_pos;
	phase_t        nxt_phase;
	logic [7:0]    nxt_fields_left;
	logic [10:0]   nxt_chars_left;
	logic          nxt_differs;
	logic          nxt_group_open;
	logic [31:0]   nxt_group_count;
	logic [31:0]   nxt_group_start;
	logic [31:0]   nxt_line_number;

	// Working values of one step.
	logic          in_fire;
	logic          white;
	logic          do_chars;
	logic          key_we;
	logic          end_line;
	logic          end_differs;
	logic          repeated;
	logic          pass;
	logic          rep_fire;
	logic [AW-1:0] end_len;
	logic [7:0]    group_rdata;
	phase_t        eff_phase;
	logic [7:0]    eff_fields;
	logic [10:0]   eff_chars;

	function automatic logic is_white(input logic [7:0] b);
		return (b == 8'd32) || ((b >= 8'd9) && (b <= 8'd13));
	endfunction

	assign in_fire   = in_valid && in_ready;
	assign in_ready  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// The store that holds the open group's key is the one not being written.
	assign group_rdata = active_q ? rdata_b_q : rdata_a_q;
	assign white       = is_white(in_data.text_byte);

	// A fresh line takes its skip settings from the registers as they stand now.
	always_comb begin
		if (pos_q == '0) begin
			eff_fields = skip_fields_q;
			eff_chars  = skip_chars_q;
			eff_phase  = (skip_fields_q != 8'd0) ? PH_LEAD : PH_CHARS;
		end else begin
			eff_fields = fields_left_q;
			eff_chars  = chars_left_q;
			eff_phase  = phase_q;
		end
	end

	// Group filter, judged on the count before the closing line is taken in.
	always_comb begin
		repeated = group_count_q > 32'd1;
		pass = (unique_only_q && !repeated) || (repeated_only_q && repeated)
			|| !(unique_only_q || repeated_only_q);
	end

	// One step: field and character skipping, key compare, line end and group bookkeeping.
	always_comb begin
		nxt_active      = active_q;
		nxt_group_len   = group_len_q;
		nxt_line_len    = line_len_q;
		nxt_pos         = pos_q;
		nxt_phase       = phase_q;
		nxt_fields_left = fields_left_q;
		nxt_chars_left  = chars_left_q;
		nxt_differs     = differs_q;
		nxt_group_open  = group_open_q;
		nxt_group_count = group_count_q;
		nxt_group_start = group_start_q;
		nxt_line_number = line_number_q;
		do_chars        = 1'b0;
		key_we          = 1'b0;
		end_line        = 1'b0;
		end_differs     = 1'b0;
		rep_fire        = 1'b0;
		end_len         = line_len_q;

		if (in_fire) begin
			if (in_data.end_of_text) begin
				if (pos_q != '0) begin
					end_line = 1'b1;
				end else begin
					// No partial line: close the open group and restart numbering.
					rep_fire        = group_open_q && pass;
					nxt_group_open  = 1'b0;
					nxt_group_count = 32'd0;
					nxt_group_len   = '0;
					nxt_line_number = 32'd0;
				end
			end else begin
				nxt_phase       = eff_phase;
				nxt_fields_left = eff_fields;
				nxt_chars_left  = eff_chars;
				case (eff_phase)
					PH_LEAD: begin
						if (!white)
							nxt_phase = PH_FIELD;
					end
					PH_FIELD: begin
						if (white)
							nxt_phase = PH_GAP;
					end
					PH_GAP: begin
						if (!white) begin
							nxt_fields_left = eff_fields - 8'd1;
							if (nxt_fields_left == 8'd0) begin
								nxt_phase = PH_CHARS;
								do_chars  = 1'b1;
							end else begin
								nxt_phase = PH_FIELD;
							end
						end
					end
					PH_CHARS: do_chars = 1'b1;
					default:  nxt_phase = PH_LEAD;
				endcase

				// Character skipping, then the byte joins the key.
				if (do_chars) begin
					if (eff_chars != 11'd0) begin
						nxt_chars_left = eff_chars - 11'd1;
					end else begin
						key_we       = 1'b1;
						nxt_line_len = line_len_q + AW'(1);
						if (group_open_q && ((line_len_q >= group_len_q)
							|| (group_rdata != in_data.text_byte)))
							nxt_differs = 1'b1;
					end
				end

				nxt_pos  = pos_q + AW'(1);
				end_line = (in_data.text_byte == NEWLINE) || (nxt_pos >= LAST_POS);
			end

			// Line end: extend the group or close it and open a new one.
			if (end_line) begin
				end_len     = nxt_line_len;
				end_differs = nxt_differs || (nxt_line_len != group_len_q);
				if (group_open_q && !end_differs) begin
					if (group_count_q != 32'hFFFF_FFFF)
						nxt_group_count = group_count_q + 32'd1;
				end else begin
					rep_fire        = group_open_q && pass;
					nxt_group_open  = 1'b1;
					nxt_group_count = 32'd1;
					nxt_group_start = line_number_q;
					nxt_group_len   = end_len;
					nxt_active      = !active_q;
				end
				nxt_line_number = line_number_q + 32'd1;
				nxt_pos         = '0;
				nxt_line_len    = '0;
				nxt_differs     = 1'b0;
			end
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unique_only_q   <= 1'b0;
			repeated_only_q <= 1'b0;
			show_count_q    <= 1'b0;
			skip_fields_q   <= 8'd0;
			skip_chars_q    <= 11'd0;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_UNIQUE_ONLY:   unique_only_q   <= cfg_data[0];
				CFG_REPEATED_ONLY: repeated_only_q <= cfg_data[0];
				CFG_SHOW_COUNT:    show_count_q    <= cfg_data[0];
				CFG_SKIP_FIELDS:   skip_fields_q   <= cfg_data[7:0];
				CFG_SKIP_CHARS:    skip_chars_q    <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	// Line and group state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q      <= 1'b0;
			group_len_q   <= '0;
			line_len_q    <= '0;
			pos_q         <= '0;
			phase_q       <= PH_LEAD;
			fields_left_q <= 8'd0;
			chars_left_q  <= 11'd0;
			differs_q     <= 1'b0;
			group_open_q  <= 1'b0;
			group_count_q <= 32'd0;
			group_start_q <= 32'd0;
			line_number_q <= 32'd0;
		end else begin
			active_q      <= nxt_active;
			group_len_q   <= nxt_group_len;
			line_len_q    <= nxt_line_len;
			pos_q         <= nxt_pos;
			phase_q       <= nxt_phase;
			fields_left_q <= nxt_fields_left;
			chars_left_q  <= nxt_chars_left;
			differs_q     <= nxt_differs;
			group_open_q  <= nxt_group_open;
			group_count_q <= nxt_group_count;
			group_start_q <= nxt_group_start;
			line_number_q <= nxt_line_number;
		end
	end

	// Output register: a new report may load in the cycle the previous one is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= rep_fire;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && rep_fire) begin
			out_q.first_line  <= group_start_q;
			out_q.occurrences <= show_count_q ? group_count_q : 32'd0;
		end
	end

	// Key stores: the line's key goes to one store while the group's key is read from the
	// other. The read is registered ahead at the next key index, with a bypass for a write
	// to the same entry in the same cycle.
	always_ff @(posedge clk) begin
		if (key_we && active_q)
			store_a[line_len_q] <= in_data.text_byte;
		if (key_we && active_q && (line_len_q == nxt_line_len))
			rdata_a_q <= in_data.text_byte;
		else
			rdata_a_q <= store_a[nxt_line_len];
	end

	always_ff @(posedge clk) begin
		if (key_we && !active_q)
			store_b[line_len_q] <= in_data.text_byte;
		if (key_we && !active_q && (line_len_q == nxt_line_len))
			rdata_b_q <= in_data.text_byte;
		else
			rdata_b_q <= store_b[nxt_line_len];
	end

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for the adjacent duplicate line filter: text beats in, group reports out.
// Predicts every report from its own model of the line grouping and compares it field by field.
// Depends on adlf_pkg and adjacent_duplicate_line_filter.
module testbench;
	import adlf_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT    = 1_000_000;
	localparam int unsigned SETTLE_CYCLES  = 4;
	localparam int unsigned HOLD_OFF_BEATS = 300;

	// Where a line stands in skipping fields and characters before its key.
	typedef enum logic [1:0] {SK_LEAD, SK_FIELD, SK_GAP, SK_KEY} skip_phase_t;

	typedef enum {ROW_CFG, ROW_BEAT} row_kind_t;
	typedef enum {CHK_MODEL, CHK_NONE, CHK_REPORT} row_check_t;

	typedef struct {
		row_kind_t                kind;
		logic [CFG_INDEX_W-1:0]   idx;
		logic [CFG_DATA_W-1:0]    val;
		in_item_t                 beat;
		row_check_t               chk;
		logic [31:0]              first;
		logic [31:0]              occ;
	} stim_row_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   in_valid  = 1'b0;
	logic                   in_ready;
	in_item_t               in_data   = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	out_item_t              out_data;
	logic                   cfg_write = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = CFG_UNIQUE_ONLY;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;

	adjacent_duplicate_line_filter u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predicted group reports, oldest first.
	out_item_t   pending_reports [$];
	out_item_t   want;
	int unsigned mismatches  = 0;
	int unsigned cycle_count = 0;

	// Idling controls for the sender and the receiver.
	bit          tx_calm     = 1'b0;
	bit          rx_calm     = 1'b0;
	int unsigned hold_cycles = 0;
	int unsigned rx_wait     = 0;

	stim_row_t   directed_rows [$];
	logic [7:0]  last_line [$];

	// Grouping model: settings, the two key memories and the per-line and per-group state.
	bit          m_unique   = 1'b0;
	bit          m_repeated = 1'b0;
	bit          m_count    = 1'b0;
	logic [7:0]  m_fields   = '0;
	logic [10:0] m_chars    = '0;

	logic [7:0]  key_mem0 [LINE_MAX_DEF] = '{default: '0};
	logic [7:0]  key_mem1 [LINE_MAX_DEF] = '{default: '0};
	bit          mem_sel    = 1'b0;
	int unsigned grp_len    = 0;
	int unsigned line_len   = 0;
	int unsigned line_pos   = 0;
	skip_phase_t skip_ph    = SK_LEAD;
	logic [7:0]  fields_rem = '0;
	logic [10:0] chars_rem  = '0;
	bit          differs    = 1'b0;
	bit          grp_open   = 1'b0;
	logic [31:0] grp_cnt    = '0;
	logic [31:0] grp_first  = '0;
	logic [31:0] line_no    = '0;

	function automatic bit is_space(logic [7:0] c);
		return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic void line_begin();
		line_len   = 0;
		line_pos   = 0;
		differs    = 1'b0;
		fields_rem = m_fields;
		chars_rem  = m_chars;
		skip_ph    = (m_fields != 0) ? SK_LEAD : SK_KEY;
	endfunction

	// Store one key byte in the free memory and compare it with the group's key.
	function automatic void key_take(logic [7:0] c);
		logic [7:0] held;
		if (line_len >= LINE_MAX_DEF)
			return;
		if (mem_sel) begin
			key_mem0[line_len] = c;
			held = key_mem1[line_len];
		end else begin
			key_mem1[line_len] = c;
			held = key_mem0[line_len];
		end
		if (grp_open && (line_len >= grp_len || held != c))
			differs = 1'b1;
		line_len++;
	endfunction

	// Field and character skipping ahead of the key.
	function automatic void byte_take(logic [7:0] c);
		if (skip_ph == SK_LEAD) begin
			if (is_space(c))
				return;
			skip_ph = SK_FIELD;
		end
		if (skip_ph == SK_GAP) begin
			if (is_space(c))
				return;
			fields_rem = fields_rem - 8'd1;
			skip_ph = (fields_rem == 0) ? SK_KEY : SK_FIELD;
		end
		if (skip_ph == SK_FIELD) begin
			if (is_space(c))
				skip_ph = SK_GAP;
			return;
		end
		if (chars_rem != 0) begin
			chars_rem--;
			return;
		end
		key_take(c);
	endfunction

	// A closing group passes the mode filter or is dropped.
	function automatic bit group_report(output out_item_t r);
		bit rep;
		rep = grp_cnt > 32'd1;
		r.first_line  = grp_first;
		r.occurrences = m_count ? grp_cnt : 32'd0;
		return (m_unique && !rep) || (m_repeated && rep) || !(m_unique || m_repeated);
	endfunction

	function automatic void line_close(output bit has, output out_item_t r);
		has = 1'b0;
		r   = '0;
		if (line_len != grp_len)
			differs = 1'b1;
		if (grp_open && !differs) begin
			if (grp_cnt != '1)
				grp_cnt++;
		end else begin
			if (grp_open)
				has = group_report(r);
			grp_open  = 1'b1;
			grp_cnt   = 32'd1;
			grp_first = line_no;
			grp_len   = line_len;
			mem_sel   = ~mem_sel;
		end
		line_no++;
		line_begin();
	endfunction

	// One accepted beat through the grouping model.
	function automatic void filter_step(in_item_t b, output bit has, output out_item_t r);
		has = 1'b0;
		r   = '0;
		if (b.end_of_text) begin
			if (line_pos > 0) begin
				line_close(has, r);
				return;
			end
			if (grp_open)
				has = group_report(r);
			grp_open = 1'b0;
			grp_cnt  = '0;
			grp_len  = 0;
			line_no  = '0;
			line_begin();
			return;
		end
		if (line_pos == 0)
			line_begin();
		byte_take(b.text_byte);
		line_pos++;
		if (b.text_byte == NEWLINE || line_pos >= LINE_MAX_DEF - 1)
			line_close(has, r);
	endfunction

	function automatic in_item_t txt(logic [7:0] c);
		return '{text_byte: c, end_of_text: 1'b0};
	endfunction

	function automatic in_item_t eot(logic [7:0] c);
		return '{text_byte: c, end_of_text: 1'b1};
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [7:0] pick_char();
		logic [7:0] c;
		if ($urandom_range(0, 9) != 0)
			return 8'("a" + $urandom_range(0, 2));
		c = 8'($urandom_range(0, 255));
		return (c == NEWLINE) ? 8'("a") : c;
	endfunction

	// Whitespace that does not end the line.
	function automatic logic [7:0] pick_space();
		case ($urandom_range(0, 4))
			0: return 8'd9;
			1: return 8'd11;
			2: return 8'd12;
			3: return 8'd13;
			default: return " ";
		endcase
	endfunction

	function automatic void cfg_row(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		stim_row_t row;
		row      = '{kind: ROW_CFG, idx: idx, val: val, beat: '0, chk: CHK_MODEL,
			first: '0, occ: '0};
		directed_rows.push_back(row);
	endfunction

	function automatic void beat_row(in_item_t b, row_check_t chk = CHK_MODEL,
		logic [31:0] first = '0, logic [31:0] occ = '0);
		stim_row_t row;
		row = '{kind: ROW_BEAT, idx: CFG_UNIQUE_ONLY, val: '0, beat: b, chk: chk,
			first: first, occ: occ};
		directed_rows.push_back(row);
	endfunction

	task automatic note_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
		$display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got,
			exp_val);
		mismatches++;
	endtask

	// Offer one beat from a falling edge; return at the falling edge after it is taken.
	task automatic send_beat(in_item_t b, row_check_t chk = CHK_MODEL,
		logic [31:0] first = '0, logic [31:0] occ = '0);
		int unsigned gap;
		bit          has;
		out_item_t   r;
		gap = tx_calm ? 0 : pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= b;
		do
			@(posedge clk);
		while (!in_ready);
		filter_step(b, has, r);
		if (chk == CHK_NONE)
			has = 1'b0;
		else if (chk == CHK_REPORT) begin
			has = 1'b1;
			r   = '{first_line: first, occurrences: occ};
		end
		if (has)
			pending_reports.push_back(r);
		@(negedge clk);
	endtask

	// Stop sending and let every report drain, then allow for a beat still in flight.
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Leaves the write enable high; the caller lowers it after the last write.
	task automatic reg_write(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			CFG_UNIQUE_ONLY:   m_unique   = val[0];
			CFG_REPEATED_ONLY: m_repeated = val[0];
			CFG_SHOW_COUNT:    m_count    = val[0];
			CFG_SKIP_FIELDS:   m_fields   = val[7:0];
			CFG_SKIP_CHARS:    m_chars    = val[10:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic apply_settings(bit u, bit rp, bit sc, logic [7:0] f, logic [10:0] ch,
		bit stray);
		settle();
		reg_write(CFG_UNIQUE_ONLY, CFG_DATA_W'(u));
		reg_write(CFG_REPEATED_ONLY, CFG_DATA_W'(rp));
		reg_write(CFG_SHOW_COUNT, CFG_DATA_W'(sc));
		reg_write(CFG_SKIP_FIELDS, CFG_DATA_W'(f));
		reg_write(CFG_SKIP_CHARS, ch);
		// Indexes past the last register must be ignored.
		if (stray) begin
			for (int i = int'(CFG_SKIP_CHARS) + 1; i < (1 << CFG_INDEX_W); i++)
				reg_write(CFG_INDEX_W'(i), CFG_DATA_W'($urandom));
		end
		cfg_write <= 1'b0;
	endtask

	// Lines built to repeat often, with mutations, noise and partial lines at end of text.
	task automatic run_text(int unsigned budget);
		logic [7:0]  line [$];
		int unsigned sent;
		int unsigned pick;
		int unsigned nf;
		int unsigned k;
		bit          partial;
		sent = 0;
		while (sent < budget) begin
			pick = $urandom_range(0, 99);
			if (pick < 45 && last_line.size() != 0)
				line = last_line;
			else if (pick < 65 && last_line.size() != 0) begin
				line    = last_line;
				k       = $urandom_range(0, line.size() - 1);
				line[k] = ($urandom_range(0, 3) == 0) ? pick_space() : pick_char();
			end else if (pick < 70) begin
				line = {};
				repeat ($urandom_range(0, 6)) line.push_back(8'($urandom_range(0, 255)));
			end else begin
				line = {};
				if ($urandom_range(0, 2) == 0)
					repeat ($urandom_range(1, 2)) line.push_back(pick_space());
				nf = $urandom_range(1, 4);
				for (int f = 0; f < nf; f++) begin
					if (f != 0)
						repeat ($urandom_range(1, 2)) line.push_back(pick_space());
					repeat ($urandom_range(1, 3)) line.push_back(pick_char());
				end
			end
			last_line = line;
			partial   = $urandom_range(0, 99) < 8;
			foreach (line[i])
				send_beat(txt(line[i]));
			if (partial)
				send_beat(eot(8'($urandom_range(0, 255))));
			else
				send_beat(txt(NEWLINE));
			if ($urandom_range(0, 99) < 3)
				send_beat(eot(8'($urandom_range(0, 255))));
			sent += line.size() + 1;
		end
		send_beat(eot(8'($urandom_range(0, 255))));
	endtask

	// Receiver: random stalls, plus a long hold-off when one is requested.
	initial begin
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_cycles != 0) begin
				out_ready <= 1'b0;
				hold_cycles--;
			end else if (rx_calm || rx_wait == 0) begin
				out_ready <= 1'b1;
				if (!rx_calm)
					rx_wait = pick_gap();
			end else begin
				out_ready <= 1'b0;
				rx_wait--;
			end
		end
	end

	// Each report beat is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_reports.size() == 0) begin
				note_mismatch("unexpected report, first_line", out_data.first_line, '0);
			end else begin
				want = pending_reports.pop_front();
				if (out_data.first_line != want.first_line)
					note_mismatch("first_line", out_data.first_line, want.first_line);
				if (out_data.occurrences != want.occurrences)
					note_mismatch("occurrences", out_data.occurrences, want.occurrences);
			end
		end
	end

	// Run limit.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL adjacent_duplicate_line_filter");
		$finish;
	end

	initial begin : stimulus
		bit writing;
		bit u;
		bit rp;
		bit sc;
		logic [7:0]  f;
		logic [10:0] ch;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Defaults after reset: every group reported, counts shown as zero.
		beat_row(txt("a"), CHK_NONE);
		beat_row(txt(NEWLINE), CHK_NONE);
		beat_row(txt("a"), CHK_NONE);
		beat_row(txt(NEWLINE), CHK_NONE);
		beat_row(txt("b"), CHK_NONE);
		beat_row(txt(NEWLINE), CHK_REPORT, 32'd0, 32'd0);
		beat_row(eot(8'hFF), CHK_REPORT, 32'd2, 32'd0);
		beat_row(eot(8'h00), CHK_NONE);
		// Unique-only with counts: the pair of lines is dropped, the single one reported.
		cfg_row(CFG_UNIQUE_ONLY, 11'd1);
		cfg_row(CFG_SHOW_COUNT, 11'd1);
		beat_row(txt("x"));
		beat_row(txt(NEWLINE), CHK_NONE);
		beat_row(txt("x"));
		beat_row(txt(NEWLINE), CHK_NONE);
		beat_row(txt("y"));
		beat_row(txt(NEWLINE), CHK_NONE);
		beat_row(eot(8'h55), CHK_REPORT, 32'd2, 32'd1);
		// Repeated-only with the whole line skipped, so that every key is empty.
		cfg_row(CFG_UNIQUE_ONLY, 11'd0);
		cfg_row(CFG_REPEATED_ONLY, 11'd1);
		cfg_row(CFG_SKIP_CHARS, 11'd1024);
		beat_row(txt("p"));
		beat_row(txt(NEWLINE), CHK_NONE);
		beat_row(txt("q"));
		beat_row(txt(NEWLINE), CHK_NONE);
		beat_row(eot(8'hAA), CHK_REPORT, 32'd0, 32'd2);
		// A partial line at end of text opens a group; the next end of text closes it.
		beat_row(txt("z"));
		beat_row(eot(NEWLINE), CHK_NONE);
		beat_row(eot(8'h00), CHK_NONE);

		writing = 1'b0;
		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CFG) begin
				if (!writing)
					settle();
				reg_write(directed_rows[i].idx, directed_rows[i].val);
				writing = 1'b1;
			end else begin
				if (writing)
					cfg_write <= 1'b0;
				writing = 1'b0;
				send_beat(directed_rows[i].beat, directed_rows[i].chk,
					directed_rows[i].first, directed_rows[i].occ);
			end
		end

		// Random phases over every mode pairing and the extremes of the skip settings.
		for (int p = 0; p < 8; p++) begin
			u  = p[0];
			rp = p[1];
			sc = p[2];
			case (p)
				0: begin f = 8'd0;   ch = 11'd0;    end
				1: begin f = 8'd255; ch = 11'd2047; end
				2: begin f = 8'd0;   ch = 11'd1024; end
				3: begin f = 8'd1;   ch = 11'd0;    end
				default: begin
					f  = 8'($urandom_range(0, 3));
					ch = 11'($urandom_range(0, 4));
				end
			endcase
			apply_settings(u, rp, sc, f, ch, p == 0);
			// One phase runs with no idling; another holds the receiver off at length.
			tx_calm = (p == 5) || (p == 6);
			rx_calm = (p == 5);
			if (p == 6)
				hold_cycles = HOLD_OFF_BEATS;
			run_text(90);
		end

		// Lines cut at the longest length: two equal, then one differing only in its tail.
		apply_settings(1'b0, 1'b0, 1'b1, 8'd0, 11'd0, 1'b0);
		tx_calm = 1'b0;
		rx_calm = 1'b0;
		repeat (2) repeat (LINE_MAX_DEF - 1) send_beat(txt("k"));
		repeat (LINE_MAX_DEF - 2) send_beat(txt("k"));
		send_beat(txt("j"));
		send_beat(txt("k"));
		send_beat(txt(NEWLINE));
		send_beat(eot(NEWLINE));

		in_valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending_reports.size() == 0)
			$display("PASS adjacent_duplicate_line_filter");
		else
			$display("FAIL adjacent_duplicate_line_filter");
		$finish;
	end

endmodule
